/* rtl/csp_pkg.sv */
// Package with the types and constants shared by the centrosymmetry block.
package csp_pkg;
  localparam int NbrCount = 12;
  localparam int KeptPairs = 6;
  localparam int CoordWidth = 24;
  localparam int DistWidth = 2 * CoordWidth + 2;
  localparam int CutWidth = 48;
  localparam int CspWidth = 53;
  localparam int IdxWidth = $clog2(NbrCount + 1);
  localparam int PairWidth = $clog2(KeptPairs + 1);

  typedef struct packed {
    logic signed [CoordWidth-1:0] rel_x;
    logic signed [CoordWidth-1:0] rel_y;
    logic signed [CoordWidth-1:0] rel_z;
    logic last_neighbor;
    logic no_neighbor;
  } in_word_t;

  typedef struct packed {
    logic [CspWidth-1:0] csp_value;
    logic too_few;
  } out_word_t;

  typedef logic signed [CoordWidth:0] sum_t;
  typedef logic [DistWidth-1:0] dist_t;
endpackage

/* rtl/csp_sqr_unit.sv */
// Shared squaring unit: accumulates the squared length of a vector, one axis per cycle while step is high.
module csp_sqr_unit (
  input  logic clk,
  input  logic clear,
  input  logic step,
  input  csp_pkg::sum_t comp,
  output csp_pkg::dist_t acc
);
  import csp_pkg::*;
  logic [CoordWidth:0] mag;
  logic [2*CoordWidth+1:0] sq;
  dist_t acc_r, acc_nxt;

  always_comb begin
    mag = comp[CoordWidth] ? (~comp + 1'b1) : comp;
    sq = mag * mag;
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (step) begin
      acc_nxt = acc_r + dist_t'(sq);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

/* rtl/centrosymmetry_parameter.sv */
// Top level of the centrosymmetry parameter block.
// Each neighbor word takes three squaring steps on the shared squaring unit plus a
// sorted insert; a word marked last then, once twelve neighbors are kept, forms
// all 66 pair sums on the same unit before the result strobes for one cycle. busy
// is low between words; the receiver cannot stall the result.
module centrosymmetry_parameter (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  csp_pkg::in_word_t in_word,
  output logic out_strobe,
  output csp_pkg::out_word_t out_word,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [csp_pkg::CutWidth-1:0] cfg_data
);
  import csp_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StIns  = 3'd2;
  localparam logic [2:0] StPair = 3'd3;
  localparam logic [2:0] StPIns = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] state_r;
  logic [1:0] ax_r;
  in_word_t item_r;
  logic [CutWidth-1:0] cut_r;
  logic signed [CoordWidth-1:0] dx_r [NbrCount];
  logic signed [CoordWidth-1:0] dy_r [NbrCount];
  logic signed [CoordWidth-1:0] dz_r [NbrCount];
  dist_t dist_r [NbrCount];
  dist_t pair_r [KeptPairs];
  logic [IdxWidth-1:0] cnt_r, pj_r, pk_r;
  logic [PairWidth-1:0] kept_r, si_r;
  logic [CspWidth:0] tot_r;
  logic sq_clear, sq_step;
  sum_t comp;
  dist_t acc;

  csp_sqr_unit u_sqr (.clk(clk), .clear(sq_clear), .step(sq_step), .comp(comp), .acc(acc));

  always_comb begin
    comp = '0;
    if (state_r == StSq) begin
      case (ax_r)
        2'd0: comp = sum_t'(item_r.rel_x);
        2'd1: comp = sum_t'(item_r.rel_y);
        default: comp = sum_t'(item_r.rel_z);
      endcase
    end else begin
      case (ax_r)
        2'd0: comp = sum_t'(dx_r[pj_r]) + sum_t'(dx_r[pk_r]);
        2'd1: comp = sum_t'(dy_r[pj_r]) + sum_t'(dy_r[pk_r]);
        default: comp = sum_t'(dz_r[pj_r]) + sum_t'(dz_r[pk_r]);
      endcase
    end
    sq_clear = (state_r == StIdle) || (state_r == StIns) || (state_r == StPIns);
    sq_step = ((state_r == StSq) || (state_r == StPair)) && (ax_r != 2'd3);
  end

  assign busy = (state_r != StIdle);
  assign cfg_ready = (state_r == StIdle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r <= '0;
      cut_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cut_r <= cfg_data;
      end
      case (state_r)
        StIdle: begin
          ax_r <= 2'd0;
          if (start) begin
            item_r <= in_word;
            state_r <= in_word.no_neighbor ? StIns : StSq;
          end
        end
        StSq: begin
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            state_r <= StIns;
          end
        end
        StIns: begin
          if (!item_r.no_neighbor && acc < dist_t'(cut_r)) begin
            if (cnt_r < IdxWidth'(NbrCount) || dist_r[NbrCount-1] > acc) begin
              for (int i = NbrCount - 1; i >= 0; i--) begin
                if (i < cnt_r) begin
                  if (dist_r[i] > acc) begin
                    if (i + 1 < NbrCount) begin
                      dist_r[i+1] <= dist_r[i];
                      dx_r[i+1] <= dx_r[i];
                      dy_r[i+1] <= dy_r[i];
                      dz_r[i+1] <= dz_r[i];
                    end
                    if (i == 0 || !(dist_r[i-1] > acc)) begin
                      dist_r[i] <= acc;
                      dx_r[i] <= item_r.rel_x;
                      dy_r[i] <= item_r.rel_y;
                      dz_r[i] <= item_r.rel_z;
                    end
                  end
                end
              end
              if (cnt_r == '0 || !(dist_r[cnt_r - 1'b1] > acc)) begin
                if (cnt_r < IdxWidth'(NbrCount)) begin
                  dist_r[cnt_r] <= acc;
                  dx_r[cnt_r] <= item_r.rel_x;
                  dy_r[cnt_r] <= item_r.rel_y;
                  dz_r[cnt_r] <= item_r.rel_z;
                end
              end
              if (cnt_r < IdxWidth'(NbrCount)) begin
                cnt_r <= cnt_r + 1'b1;
              end
            end
          end
          if (!item_r.last_neighbor) begin
            state_r <= StIdle;
          end else if (cnt_r < IdxWidth'(NbrCount) &&
                       !(cnt_r == IdxWidth'(NbrCount - 1) && !item_r.no_neighbor &&
                         acc < dist_t'(cut_r))) begin
            tot_r <= '0;
            state_r <= StOut;
          end else begin
            pj_r <= '0;
            pk_r <= IdxWidth'(1);
            kept_r <= '0;
            ax_r <= 2'd0;
            state_r <= StPair;
          end
        end
        StPair: begin
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) begin
            state_r <= StPIns;
          end
        end
        StPIns: begin
          if (kept_r < PairWidth'(KeptPairs) || pair_r[KeptPairs-1] > acc) begin
            for (int i = KeptPairs - 1; i >= 0; i--) begin
              if (i < kept_r) begin
                if (pair_r[i] > acc) begin
                  if (i + 1 < KeptPairs) begin
                    pair_r[i+1] <= pair_r[i];
                  end
                  if (i == 0 || !(pair_r[i-1] > acc)) begin
                    pair_r[i] <= acc;
                  end
                end
              end
            end
            if (kept_r < PairWidth'(KeptPairs)) begin
              if (kept_r == '0 || !(pair_r[kept_r - 1'b1] > acc)) begin
                pair_r[kept_r] <= acc;
              end
              kept_r <= kept_r + 1'b1;
            end
          end
          ax_r <= 2'd0;
          if (pk_r == IdxWidth'(NbrCount - 1)) begin
            if (pj_r == IdxWidth'(NbrCount - 2)) begin
              si_r <= '0;
              tot_r <= '0;
              state_r <= StSum;
            end else begin
              pj_r <= pj_r + 1'b1;
              pk_r <= pj_r + IdxWidth'(2);
              state_r <= StPair;
            end
          end else begin
            pk_r <= pk_r + 1'b1;
            state_r <= StPair;
          end
        end
        StSum: begin
          tot_r <= tot_r + (CspWidth+1)'(pair_r[si_r]);
          si_r <= si_r + 1'b1;
          if (si_r == kept_r - 1'b1) begin
            state_r <= StOut;
          end
        end
        StOut: begin
          out_strobe <= 1'b1;
          out_word.too_few <= (kept_r == '0) || (tot_r == '0 && cnt_r < IdxWidth'(NbrCount));
          out_word.csp_value <= tot_r[CspWidth] ? '1 : tot_r[CspWidth-1:0];
          cnt_r <= '0;
          kept_r <= '0;
          state_r <= StIdle;
        end
        default: state_r <= StIdle;
      endcase
    end
  end
endmodule
